>>> src/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg: shared types and constants of the tap tempo feedback echo
// Sizes, register indexes, note codes, word structs and the constant tables
// used by the sequencer and its arithmetic unit.
// ----------------------------------------------------------------------------
package tte_pkg;

   // Sizing
   localparam int SAMPLE_BITS = 24;
   localparam int DELAY_DEPTH = 131072;
   localparam int TAP_HISTORY = 4;

   localparam int ADDR_W  = $clog2(DELAY_DEPTH);
   localparam int DLY_W   = 17;
   localparam int GAIN_W  = 16;
   localparam int NOTE_W  = 2;
   localparam int TIME_W  = 32;
   localparam int GAP_W   = 11;
   localparam int CNT_W   = $clog2(TAP_HISTORY + 1);
   localparam int HEAD_W  = (TAP_HISTORY > 1) ? $clog2(TAP_HISTORY) : 1;
   localparam int SUM_W   = GAP_W + CNT_W;
   localparam int MIX_W   = SAMPLE_BITS + 1;
   localparam int PTR_W   = ((ADDR_W > DLY_W) ? ADDR_W : DLY_W) + 1;
   localparam int MUL_W   = (MIX_W > 28) ? MIX_W : 28;
   localparam int PROD_W  = 2 * MUL_W;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_GAIN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_LEVEL     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_TYPE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_DELAY = 3'd4;

   localparam logic [GAIN_W-1:0] DECAY_GAIN_RST    = 16'd32768;
   localparam logic [GAIN_W-1:0] MIX_LEVEL_RST     = 16'd32768;
   localparam logic [GAIN_W-1:0] OUTPUT_GAIN_RST   = 16'd4096;
   localparam logic [DLY_W-1:0]  INITIAL_DELAY_RST = 17'd48000;

   // Request kinds and note codes
   localparam logic REQ_AUDIO = 1'b0;
   localparam logic REQ_TAP   = 1'b1;

   localparam logic [NOTE_W-1:0] NOTE_QUARTER = 2'd0;
   localparam logic [NOTE_W-1:0] NOTE_TRIPLET = 2'd1;
   localparam logic [NOTE_W-1:0] NOTE_DOTTED  = 2'd2;

   // Arithmetic constants
   localparam int DECAY_SHIFT     = 16;
   localparam int GAIN_SHIFT      = 12;
   localparam int TAP_LIMIT_MS    = 2000;
   localparam int SAMPLES_PER_MS  = 48;
   localparam int TRIPLET_NUM     = 333;
   localparam int DOTTED_NUM      = 3;
   localparam int DOTTED_SHIFT    = 2;
   localparam int RECIP_1000      = 68719477;   // ceil(2^36 / 1000)
   localparam int RECIP_1000_SH   = 36;
   localparam int RECIP_CNT_SH    = 20;
   localparam int RECIP_CNT_W     = 21;

   // ceil(2^20 / n) for a history fill count n; exact for n * 1999 range sums
   localparam logic [RECIP_CNT_W-1:0] COUNT_RECIP [0:16] = '{
      21'd0,      21'd1048576, 21'd524288, 21'd349526, 21'd262144,
      21'd209716, 21'd174763,  21'd149797, 21'd131072, 21'd116509,
      21'd104858, 21'd95326,   21'd87382,  21'd80660,  21'd74899,
      21'd69906,  21'd65536
   };

   // Channel words
   typedef struct packed {
      logic                          req_type;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [TIME_W-1:0]             tap_time_ms;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic [DLY_W-1:0]              delay_samples;
      logic                          tap_accepted;
   } rsp_word_type;

   // Request to the shared multiplier
   typedef struct packed {
      logic                    load;
      logic signed [MUL_W-1:0] op_a;
      logic signed [MUL_W-1:0] op_b;
   } mul_req_type;

endpackage

>>> src/tte_ram.sv
// ----------------------------------------------------------------------------
// tte_ram: generic single write, single read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tte_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tte_mul.sv
// ----------------------------------------------------------------------------
// tte_mul: shared signed multiplier
// Multiply the two operands and hold the product in a register until the
// next load.
// ----------------------------------------------------------------------------
module tte_mul (
   input  logic                                clock,
   input  tte_pkg::mul_req_type                mul_req,
   output logic signed [tte_pkg::PROD_W-1:0]   prod
);

   logic signed [tte_pkg::PROD_W-1:0] prod_ff;
   logic signed [tte_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (mul_req.load) begin
         prod_in = tte_pkg::PROD_W'(mul_req.op_a) * tte_pkg::PROD_W'(mul_req.op_b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> src/tap_tempo_feedback_echo.sv
// ----------------------------------------------------------------------------
// tap_tempo_feedback_echo: mono feedback echo with tap tempo
// Top level: sequencer, delay store, tap history and output register.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole delay store to zero, one entry a
// cycle, holding req_stall high until the sweep is done; configuration
// writes are taken at any time. Every word then goes through one shared
// multiplier under a small sequencer, one step per cycle, and the block
// takes no new word until the current one has put its result in the output
// register. An audio word steps through delay scaling, store read, feedback,
// mix and output gain products. A tap word whose gap is 2000 ms or more goes
// straight on to delay scaling; an accepted one first sums the gap history
// one entry at a time and scales the sum by a reciprocal. A finished result
// may wait in the output register while the next word is accepted; the
// sequencer only holds at its last step if that register is occupied and stalled.
// ----------------------------------------------------------------------------
module tap_tempo_feedback_echo (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tte_pkg::req_word_type              req_data,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tte_pkg::rsp_word_type              rsp_data,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tte_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tte_pkg::CSR_DATA_W-1:0]     csr_data
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAP,
      ST_SUM,
      ST_DIV,
      ST_BASE,
      ST_DLY_MUL,
      ST_DLY_RECIP,
      ST_DLY_SET,
      ST_READ,
      ST_MUL_FB,
      ST_MUL_MIX,
      ST_MIX,
      ST_MUL_OUT,
      ST_DONE
   } state_type;

   // Clamp a wide signed value to the sample range
   function automatic logic signed [tte_pkg::SAMPLE_BITS-1:0] sat_sample(
      input logic signed [tte_pkg::PROD_W-1:0] v
   );
      logic signed [tte_pkg::PROD_W-1:0] hi;
      logic signed [tte_pkg::PROD_W-1:0] lo;
      hi = {{(tte_pkg::PROD_W - tte_pkg::SAMPLE_BITS + 1){1'b0}},
            {(tte_pkg::SAMPLE_BITS - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[tte_pkg::SAMPLE_BITS-1:0];
      end else if (v < lo) begin
         return lo[tte_pkg::SAMPLE_BITS-1:0];
      end
      return v[tte_pkg::SAMPLE_BITS-1:0];
   endfunction

   // ---------------------------------------------------------------- state
   state_type                                 state_ff, state_in;
   logic [tte_pkg::ADDR_W-1:0]                clr_addr_ff, clr_addr_in;
   tte_pkg::req_word_type                     req_ff, req_in;
   logic [tte_pkg::ADDR_W-1:0]                wp_ff, wp_in;
   logic [tte_pkg::DLY_W-1:0]                 delay_ff, delay_in;
   logic [tte_pkg::DLY_W-1:0]                 tap_base_ff, tap_base_in;
   logic                                      has_tap_ff, has_tap_in;
   logic [tte_pkg::GAP_W-1:0]                 gaps_ff [tte_pkg::TAP_HISTORY];
   logic [tte_pkg::GAP_W-1:0]                 gaps_in [tte_pkg::TAP_HISTORY];
   logic [tte_pkg::CNT_W-1:0]                 count_ff, count_in;
   logic [tte_pkg::HEAD_W-1:0]                head_ff, head_in;
   logic [tte_pkg::TIME_W-1:0]                last_tap_ff, last_tap_in;
   logic [tte_pkg::SUM_W-1:0]                 sum_ff, sum_in;
   logic [tte_pkg::CNT_W-1:0]                 idx_ff, idx_in;
   logic                                      tap_ok_ff, tap_ok_in;
   logic signed [tte_pkg::SAMPLE_BITS-1:0]    wet_ff, wet_in;
   logic signed [tte_pkg::MIX_W-1:0]          mix_ff, mix_in;
   logic                                      rsp_valid_ff, rsp_valid_in;
   tte_pkg::rsp_word_type                     rsp_ff, rsp_in;

   // configuration registers
   logic [tte_pkg::GAIN_W-1:0]                decay_ff, decay_in;
   logic [tte_pkg::GAIN_W-1:0]                mix_lvl_ff, mix_lvl_in;
   logic [tte_pkg::GAIN_W-1:0]                gain_ff, gain_in;
   logic [tte_pkg::NOTE_W-1:0]                note_ff, note_in;
   logic [tte_pkg::DLY_W-1:0]                 init_dly_ff, init_dly_in;

   // ------------------------------------------------------------ datapath
   tte_pkg::mul_req_type                      mul_req;
   logic signed [tte_pkg::PROD_W-1:0]         mul_prod;

   logic                                      ram_wr_en;
   logic [tte_pkg::ADDR_W-1:0]                ram_wr_addr;
   logic [tte_pkg::SAMPLE_BITS-1:0]           ram_wr_data;
   logic                                      ram_rd_en;
   logic [tte_pkg::ADDR_W-1:0]                ram_rd_addr;
   logic [tte_pkg::SAMPLE_BITS-1:0]           ram_rd_data;

   logic [tte_pkg::TIME_W-1:0]                tap_gap;
   logic [tte_pkg::CNT_W-1:0]                 idx_next;
   logic [tte_pkg::GAP_W-1:0]                 tap_avg;
   logic [tte_pkg::DLY_W-1:0]                 base_dly;
   logic [tte_pkg::DLY_W-1:0]                 scaled_dly;
   logic [tte_pkg::PTR_W-1:0]                 wp_ext;
   logic [tte_pkg::PTR_W-1:0]                 dly_ext;
   logic [tte_pkg::PTR_W-1:0]                 rd_ptr;
   logic signed [tte_pkg::MIX_W-1:0]          prod_q16;
   logic signed [tte_pkg::MIX_W-1:0]          dry_sum;
   logic                                      out_free;

   tte_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (mul_prod)
   );

   tte_ram #(
      .WIDTH (tte_pkg::SAMPLE_BITS),
      .DEPTH (tte_pkg::DELAY_DEPTH)
   ) u_echo_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Gap since the last tap, modulo 2^32
   assign tap_gap  = req_ff.tap_time_ms - last_tap_ff;
   assign idx_next = idx_ff + 1'b1;
   assign tap_avg  = mul_prod[tte_pkg::RECIP_CNT_SH +: tte_pkg::GAP_W];
   assign base_dly = has_tap_ff ? tap_base_ff : init_dly_ff;

   // Read pointer trails the write pointer by the delay, wrapping at the depth
   assign wp_ext  = tte_pkg::PTR_W'(wp_ff);
   assign dly_ext = tte_pkg::PTR_W'(delay_ff);
   assign rd_ptr  = (wp_ext >= dly_ext) ? (wp_ext - dly_ext)
                  : (wp_ext + tte_pkg::PTR_W'(tte_pkg::DELAY_DEPTH) - dly_ext);

   // floor(product / 2^16), exact since the product stays small
   assign prod_q16 = mul_prod[tte_pkg::DECAY_SHIFT +: tte_pkg::MIX_W];
   assign dry_sum  = tte_pkg::MIX_W'(req_ff.sample_in) + prod_q16;

   // Output register frees up when it is empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Pick the note-scaled delay out of the product
   always_comb begin
      case (note_ff)
         tte_pkg::NOTE_QUARTER: scaled_dly = mul_prod[tte_pkg::DLY_W-1:0];
         tte_pkg::NOTE_TRIPLET: scaled_dly = mul_prod[tte_pkg::RECIP_1000_SH +: tte_pkg::DLY_W];
         // dotted eighth, and the unused code behaves the same
         default:               scaled_dly = mul_prod[tte_pkg::DOTTED_SHIFT +: tte_pkg::DLY_W];
      endcase
   end

   // ----------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      req_in       = req_ff;
      wp_in        = wp_ff;
      delay_in     = delay_ff;
      tap_base_in  = tap_base_ff;
      has_tap_in   = has_tap_ff;
      gaps_in      = gaps_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      last_tap_in  = last_tap_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;
      tap_ok_in    = tap_ok_ff;
      wet_in       = wet_ff;
      mix_in       = mix_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      decay_in     = decay_ff;
      mix_lvl_in   = mix_lvl_ff;
      gain_in      = gain_ff;
      note_in      = note_ff;
      init_dly_in  = init_dly_ff;

      mul_req      = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wp_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_ptr[tte_pkg::ADDR_W-1:0];

      // drop the result once the consumer takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // register writes; unknown indexes are ignored
      if (csr_valid) begin
         unique case (csr_index)
            tte_pkg::CSR_DECAY_GAIN:    decay_in    = csr_data[tte_pkg::GAIN_W-1:0];
            tte_pkg::CSR_MIX_LEVEL:     mix_lvl_in  = csr_data[tte_pkg::GAIN_W-1:0];
            tte_pkg::CSR_OUTPUT_GAIN:   gain_in     = csr_data[tte_pkg::GAIN_W-1:0];
            tte_pkg::CSR_NOTE_TYPE:     note_in     = csr_data[tte_pkg::NOTE_W-1:0];
            tte_pkg::CSR_INITIAL_DELAY: init_dly_in = csr_data[tte_pkg::DLY_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the delay store to zero
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == tte_pkg::ADDR_W'(tte_pkg::DELAY_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = (req_data.req_type == tte_pkg::REQ_TAP) ? ST_TAP : ST_DLY_MUL;
            end
         end

         ST_TAP: begin
            last_tap_in = req_ff.tap_time_ms;
            if (tap_gap < tte_pkg::TIME_W'(tte_pkg::TAP_LIMIT_MS)) begin
               tap_ok_in        = 1'b1;
               gaps_in[head_ff] = tap_gap[tte_pkg::GAP_W-1:0];
               head_in = (head_ff == tte_pkg::HEAD_W'(tte_pkg::TAP_HISTORY - 1))
                       ? '0 : head_ff + 1'b1;
               if (count_ff != tte_pkg::CNT_W'(tte_pkg::TAP_HISTORY)) begin
                  count_in = count_ff + 1'b1;
               end
               sum_in   = '0;
               idx_in   = '0;
               state_in = ST_SUM;
            end else begin
               // gap too long: restart the history, keep the base delay
               tap_ok_in = 1'b0;
               count_in  = '0;
               head_in   = '0;
               state_in  = ST_DLY_MUL;
            end
         end

         ST_SUM: begin
            // accumulate one history entry per cycle
            sum_in = sum_ff + tte_pkg::SUM_W'(gaps_ff[idx_ff[tte_pkg::HEAD_W-1:0]]);
            idx_in = idx_next;
            if (idx_next == count_ff) begin
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // average by reciprocal of the fill count
            mul_req.load = 1'b1;
            mul_req.op_a = signed'(tte_pkg::MUL_W'(sum_ff));
            mul_req.op_b = signed'(tte_pkg::MUL_W'(tte_pkg::COUNT_RECIP[count_ff]));
            state_in     = ST_BASE;
         end

         ST_BASE: begin
            tap_base_in = tte_pkg::DLY_W'(tte_pkg::DLY_W'(tap_avg)
                        * tte_pkg::DLY_W'(tte_pkg::SAMPLES_PER_MS));
            has_tap_in  = 1'b1;
            state_in    = ST_DLY_MUL;
         end

         ST_DLY_MUL: begin
            // base times the note numerator
            mul_req.load = 1'b1;
            mul_req.op_a = signed'(tte_pkg::MUL_W'(base_dly));
            case (note_ff)
               tte_pkg::NOTE_QUARTER: mul_req.op_b = tte_pkg::MUL_W'(1);
               tte_pkg::NOTE_TRIPLET: mul_req.op_b = tte_pkg::MUL_W'(tte_pkg::TRIPLET_NUM);
               default:               mul_req.op_b = tte_pkg::MUL_W'(tte_pkg::DOTTED_NUM);
            endcase
            state_in = ST_DLY_RECIP;
         end

         ST_DLY_RECIP: begin
            // triplet: divide by 1000 through the reciprocal
            if (note_ff == tte_pkg::NOTE_TRIPLET) begin
               mul_req.load = 1'b1;
               mul_req.op_a = signed'(mul_prod[tte_pkg::MUL_W-1:0]);
               mul_req.op_b = tte_pkg::MUL_W'(tte_pkg::RECIP_1000);
            end
            state_in = ST_DLY_SET;
         end

         ST_DLY_SET: begin
            // clamp to one sample up to one less than the store length
            if (scaled_dly == '0) begin
               delay_in = tte_pkg::DLY_W'(1);
            end else if (32'(scaled_dly) > tte_pkg::DELAY_DEPTH - 1) begin
               delay_in = tte_pkg::DLY_W'(tte_pkg::DELAY_DEPTH - 1);
            end else begin
               delay_in = scaled_dly;
            end
            state_in = (req_ff.req_type == tte_pkg::REQ_TAP) ? ST_DONE : ST_READ;
         end

         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_MUL_FB;
         end

         ST_MUL_FB: begin
            wet_in       = signed'(ram_rd_data);
            mul_req.load = 1'b1;
            mul_req.op_a = tte_pkg::MUL_W'(signed'(ram_rd_data));
            mul_req.op_b = signed'(tte_pkg::MUL_W'(decay_ff));
            state_in     = ST_MUL_MIX;
         end

         ST_MUL_MIX: begin
            // write back dry plus decayed echo, saturated
            ram_wr_en    = 1'b1;
            ram_wr_data  = sat_sample(tte_pkg::PROD_W'(dry_sum));
            mul_req.load = 1'b1;
            mul_req.op_a = tte_pkg::MUL_W'(wet_ff);
            mul_req.op_b = signed'(tte_pkg::MUL_W'(mix_lvl_ff));
            state_in     = ST_MIX;
         end

         ST_MIX: begin
            mix_in   = dry_sum;
            state_in = ST_MUL_OUT;
         end

         ST_MUL_OUT: begin
            mul_req.load = 1'b1;
            mul_req.op_a = tte_pkg::MUL_W'(mix_ff);
            mul_req.op_b = signed'(tte_pkg::MUL_W'(gain_ff));
            state_in     = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.delay_samples = delay_ff;
               if (req_ff.req_type == tte_pkg::REQ_TAP) begin
                  rsp_in.sample_out   = '0;
                  rsp_in.tap_accepted = tap_ok_ff;
               end else begin
                  rsp_in.sample_out   = sat_sample(mul_prod >>> tte_pkg::GAIN_SHIFT);
                  rsp_in.tap_accepted = 1'b0;
                  wp_in = (wp_ff == tte_pkg::ADDR_W'(tte_pkg::DELAY_DEPTH - 1))
                        ? '0 : wp_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      // payload registers
      req_ff   <= req_in;
      delay_ff <= delay_in;
      gaps_ff  <= gaps_in;
      sum_ff   <= sum_in;
      idx_ff   <= idx_in;
      tap_ok_ff <= tap_ok_in;
      wet_ff   <= wet_in;
      mix_ff   <= mix_in;
      rsp_ff   <= rsp_in;
      // control and configuration
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         wp_ff        <= '0;
         tap_base_ff  <= '0;
         has_tap_ff   <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         last_tap_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         decay_ff     <= tte_pkg::DECAY_GAIN_RST;
         mix_lvl_ff   <= tte_pkg::MIX_LEVEL_RST;
         gain_ff      <= tte_pkg::OUTPUT_GAIN_RST;
         note_ff      <= tte_pkg::NOTE_QUARTER;
         init_dly_ff  <= tte_pkg::INITIAL_DELAY_RST;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         wp_ff        <= wp_in;
         tap_base_ff  <= tap_base_in;
         has_tap_ff   <= has_tap_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         last_tap_ff  <= last_tap_in;
         rsp_valid_ff <= rsp_valid_in;
         decay_ff     <= decay_in;
         mix_lvl_ff   <= mix_lvl_in;
         gain_ff      <= gain_in;
         note_ff      <= note_in;
         init_dly_ff  <= init_dly_in;
      end
   end

   // ------------------------------------------------------------- outputs
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

>>> src/tte_chk.sv
// ----------------------------------------------------------------------------
// tte_chk: port checker for the tap tempo feedback echo
// Watch the top level's channels over time; bound to every instance.
// ----------------------------------------------------------------------------
module tte_chk (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  tte_pkg::rsp_word_type rsp_data
);

   // reset starts the store sweep, so no word is taken right after it
   a_reset_busy: assert property (@(posedge clock) reset |=> req_stall)
      else $error("request taken right after reset");

   // one word at a time: busy after every accepted word
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request channel open right after an accepted word");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or dropped");

   // the delay in use never clamps to zero
   a_delay_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.delay_samples != '0)
      else $error("zero delay reported");

   // accepted tap results carry no audio
   a_tap_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tap_accepted |-> rsp_data.sample_out == '0)
      else $error("tap result carries a sample");

endmodule

bind tap_tempo_feedback_echo tte_chk u_tte_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

>>> test/tap_tempo_feedback_echo_tb.sv
// ----------------------------------------------------------------------------
// tap_tempo_feedback_echo_tb: self-checking bench for the tap tempo echo
// Drives audio and tap words with random pacing on both channels. A local
// model of the delay store, feedback path and tap history predicts every
// response word. Registers are rewritten between phases while the block is
// idle, covering gain extremes, every note code and the delay clamps.
// ----------------------------------------------------------------------------
module tap_tempo_feedback_echo_tb;
   import tte_pkg::*;

   localparam int     RESET_CYCLES   = 5;
   localparam int     MAX_WAIT       = 12;
   localparam int     PHASE_WORDS    = 100;
   localparam int     PRE_TAP_PHASES = 4;
   localparam int     TAP_PHASES     = 12;
   localparam int     SETTLE_CYCLES  = 40;
   // The store sweep after reset holds req_stall until every entry is cleared.
   localparam int     WATCHDOG_LIMIT = 4 * DELAY_DEPTH;
   localparam int     TRIPLET_DEN    = 1000;
   localparam longint SAT_HI         = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO         = -SAT_HI - 1;

   localparam logic [CSR_IDX_W-1:0]   CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0]   CSR_SPARE_HI = 3'd7;
   localparam logic [SAMPLE_BITS-1:0] PEAK_POS     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] PEAK_NEG     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   tap_tempo_feedback_echo dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Words waiting to be sent, and responses owed by the block, oldest first.
   req_word_type outbound_words[$];
   rsp_word_type owed_echoes[$];

   // Local copy of the register file.
   logic [GAIN_W-1:0] decay_gain  = DECAY_GAIN_RST;
   logic [GAIN_W-1:0] mix_level   = MIX_LEVEL_RST;
   logic [GAIN_W-1:0] output_gain = OUTPUT_GAIN_RST;
   logic [NOTE_W-1:0] note_code   = NOTE_QUARTER;
   logic [DLY_W-1:0]  start_delay = INITIAL_DELAY_RST;

   // Local copy of the block state.
   logic signed [SAMPLE_BITS-1:0] echo_mem [DELAY_DEPTH];
   logic [ADDR_W-1:0]             write_ptr  = '0;
   logic [DLY_W-1:0]              tap_base   = '0;
   logic                          tap_locked = 1'b0;
   logic [GAP_W-1:0]              gap_hist [TAP_HISTORY];
   logic [CNT_W-1:0]              hist_fill  = '0;
   logic [HEAD_W-1:0]             hist_head  = '0;
   logic [TIME_W-1:0]             prev_tap   = '0;

   // Stimulus side: time of the last queued tap, and pacing modes.
   logic [TIME_W-1:0] stim_last_tap = '0;
   bit                send_calm     = 1'b0;
   bit                take_calm     = 1'b0;
   int                fault_count   = 0;
   int                quiet_cycles  = 0;
   int unsigned       send_wait     = 0;
   int unsigned       take_wait     = 0;

   initial begin
      foreach (echo_mem[i]) echo_mem[i] = '0;
      foreach (gap_hist[i]) gap_hist[i] = '0;
   end

   // ----------------------------------------------------------------------
   // Prediction
   // ----------------------------------------------------------------------
   function automatic longint clip(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   // Delay in use: base scaled by the note factor, clamped to the store.
   function automatic logic [DLY_W-1:0] echo_delay();
      longint unsigned base;
      longint unsigned d;
      base = tap_locked ? tap_base : start_delay;
      case (note_code)
         NOTE_QUARTER: d = base;
         NOTE_TRIPLET: d = (base * TRIPLET_NUM) / TRIPLET_DEN;
         // dotted eighth; the unused code falls here too
         default:      d = (base * DOTTED_NUM) >> DOTTED_SHIFT;
      endcase
      if (d < 1) d = 1;
      if (d > DELAY_DEPTH - 1) d = DELAY_DEPTH - 1;
      return d[DLY_W-1:0];
   endfunction

   // Advance the local state by one accepted word and queue its response.
   task automatic predict_echo(input req_word_type w);
      rsp_word_type      echo;
      longint            dry, wet, fb, mixv, outv;
      int                rp;
      logic [TIME_W-1:0] gap;
      int unsigned       sum;
      echo = '0;
      if (w.req_type == REQ_AUDIO) begin
         rp   = (int'(write_ptr) + DELAY_DEPTH - int'(echo_delay())) % DELAY_DEPTH;
         dry  = $signed(w.sample_in);
         wet  = echo_mem[rp];
         fb   = clip(dry + ((wet * $signed({1'b0, decay_gain})) >>> DECAY_SHIFT));
         mixv = dry + ((wet * $signed({1'b0, mix_level})) >>> DECAY_SHIFT);
         outv = clip((mixv * $signed({1'b0, output_gain})) >>> GAIN_SHIFT);
         echo_mem[write_ptr] = fb[SAMPLE_BITS-1:0];
         write_ptr = ADDR_W'((int'(write_ptr) + 1) % DELAY_DEPTH);
         echo.sample_out = outv[SAMPLE_BITS-1:0];
      end else begin
         gap = w.tap_time_ms - prev_tap;
         if (gap < TAP_LIMIT_MS) begin
            // Record the gap, then average only the entries written so far.
            gap_hist[hist_head] = gap[GAP_W-1:0];
            hist_head = HEAD_W'((int'(hist_head) + 1) % TAP_HISTORY);
            if (hist_fill < TAP_HISTORY) hist_fill = hist_fill + 1'b1;
            sum = 0;
            for (int i = 0; i < hist_fill; i++) sum += gap_hist[i];
            tap_base   = DLY_W'((sum / hist_fill) * SAMPLES_PER_MS);
            tap_locked = 1'b1;
            echo.tap_accepted = 1'b1;
         end else begin
            // Long pause: drop the history, keep the base delay.
            hist_fill = '0;
            hist_head = '0;
         end
         prev_tap = w.tap_time_ms;
      end
      echo.delay_samples = echo_delay();
      owed_echoes.push_back(echo);
   endtask

   // ----------------------------------------------------------------------
   // Channel pacing
   // ----------------------------------------------------------------------
   function automatic int unsigned next_wait(bit calm);
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Request driver: hold a word until taken, then idle a drawn number of
   // cycles before presenting the next one.
   always @(posedge clock) begin
      logic present;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         present = req_valid;
         if (req_valid && !req_stall) begin
            predict_echo(req_data);
            present   = 1'b0;
            send_wait = next_wait(send_calm);
         end
         if (!present) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (outbound_words.size() > 0) begin
               req_data <= outbound_words.pop_front();
               present = 1'b1;
            end
         end
         req_valid <= present;
      end
   end

   // Response monitor: check each taken word, then stall a drawn number of
   // cycles.
   always @(posedge clock) begin
      logic         hold;
      rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         take_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_echoes.size() == 0) begin
               $display("%0t: response with none owed, got %h", $time, rsp_data);
               fault_count++;
            end else begin
               want = owed_echoes.pop_front();
               if (rsp_data.sample_out !== want.sample_out) begin
                  $display("%0t: sample_out expected %0d, got %0d", $time,
                           want.sample_out, rsp_data.sample_out);
                  fault_count++;
               end
               if (rsp_data.delay_samples !== want.delay_samples) begin
                  $display("%0t: delay_samples expected %0d, got %0d", $time,
                           want.delay_samples, rsp_data.delay_samples);
                  fault_count++;
               end
               if (rsp_data.tap_accepted !== want.tap_accepted) begin
                  $display("%0t: tap_accepted expected %0d, got %0d", $time,
                           want.tap_accepted, rsp_data.tap_accepted);
                  fault_count++;
               end
            end
            take_wait = next_wait(take_calm);
         end
         hold = (take_wait > 0);
         if (hold) take_wait--;
         rsp_stall <= hold;
      end
   end

   // Watchdog: end the run after too long a stretch with no handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tap_tempo_feedback_echo_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ----------------------------------------------------------------------
   // Stimulus
   // ----------------------------------------------------------------------
   // Write one register and mirror it locally once the port takes it.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DECAY_GAIN:    decay_gain  = val[GAIN_W-1:0];
         CSR_MIX_LEVEL:     mix_level   = val[GAIN_W-1:0];
         CSR_OUTPUT_GAIN:   output_gain = val[GAIN_W-1:0];
         CSR_NOTE_TYPE:     note_code   = val[NOTE_W-1:0];
         CSR_INITIAL_DELAY: start_delay = val[DLY_W-1:0];
         default: ;
      endcase
   endtask

   task automatic queue_audio(input logic [SAMPLE_BITS-1:0] s);
      req_word_type w;
      w.req_type    = REQ_AUDIO;
      w.sample_in   = s;
      w.tap_time_ms = $urandom;
      outbound_words.push_back(w);
   endtask

   task automatic queue_tap(input logic [TIME_W-1:0] t);
      req_word_type w;
      w.req_type    = REQ_TAP;
      w.sample_in   = SAMPLE_BITS'($urandom);
      w.tap_time_ms = t;
      stim_last_tap = t;
      outbound_words.push_back(w);
   endtask

   // Hold until every queued word is sent and every response is in, then
   // redraw the pacing so that some phases run without any idling. Check on
   // the falling edge, once the rising edge's updates have settled.
   task automatic drain_echoes();
      do @(negedge clock);
      while (outbound_words.size() != 0 || req_valid || owed_echoes.size() != 0);
      send_calm = ($urandom_range(0, 3) == 0);
      take_calm = ($urandom_range(0, 3) == 0);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain(logic [GAIN_W-1:0] nominal,
                                                   int unsigned cap);
      logic [GAIN_W-1:0] g;
      case ($urandom_range(0, 5))
         0:       g = '0;
         1:       g = '1;
         2:       g = nominal;
         default: g = $urandom_range(0, cap);
      endcase
      return g;
   endfunction

   // Rewrite every register with random upper bits that the block must drop.
   task automatic setup_phase();
      logic [CSR_DATA_W-1:0] word;
      word = $urandom; word[GAIN_W-1:0] = pick_gain(DECAY_GAIN_RST, 65535);
      write_reg(CSR_DECAY_GAIN, word);
      word = $urandom; word[GAIN_W-1:0] = pick_gain(MIX_LEVEL_RST, 65535);
      write_reg(CSR_MIX_LEVEL, word);
      word = $urandom; word[GAIN_W-1:0] = pick_gain(OUTPUT_GAIN_RST, 8191);
      write_reg(CSR_OUTPUT_GAIN, word);
      word = $urandom; word[NOTE_W-1:0] = $urandom_range(0, 3);
      write_reg(CSR_NOTE_TYPE, word);
      // Short delays keep the echo path busy within one phase.
      word = $urandom;
      case ($urandom_range(0, 7))
         0:       word[DLY_W-1:0] = '0;
         1:       word[DLY_W-1:0] = '1;
         2:       word[DLY_W-1:0] = $urandom;
         default: word[DLY_W-1:0] = $urandom_range(1, 120);
      endcase
      write_reg(CSR_INITIAL_DELAY, word);
      if ($urandom_range(0, 3) == 0)
         write_reg($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI), $urandom);
   endtask

   task automatic random_phase(bit with_taps);
      logic [TIME_W-1:0] gap;
      logic [SAMPLE_BITS-1:0] s;
      for (int n = 0; n < PHASE_WORDS; n++) begin
         if (with_taps && $urandom_range(0, 5) == 0) begin
            // Mostly tight tap runs, so the delay stays short enough to echo.
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: gap = $urandom_range(0, 4);
               5, 6, 7:       gap = $urandom_range(0, TAP_LIMIT_MS - 1);
               8:             gap = $urandom_range(TAP_LIMIT_MS, 32'hFFFF_FFFF);
               default:       gap = $urandom_range(TAP_LIMIT_MS - 1, TAP_LIMIT_MS);
            endcase
            queue_tap(stim_last_tap + gap);
         end else begin
            case ($urandom_range(0, 7))
               0:       s = PEAK_POS;
               1:       s = PEAK_NEG;
               default: s = $urandom;
            endcase
            queue_audio(s);
         end
      end
      drain_echoes();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: long delay, so the store reads back zero.
      queue_audio(PEAK_POS);
      queue_audio(PEAK_NEG);
      queue_audio('0);
      queue_audio('1);
      drain_echoes();

      // Zero base delay clamps up to one sample; full gains saturate; the
      // unused note code acts as dotted eighth; spare indexes are ignored.
      write_reg(CSR_INITIAL_DELAY, '0);
      write_reg(CSR_DECAY_GAIN, '1);
      write_reg(CSR_MIX_LEVEL, '1);
      write_reg(CSR_OUTPUT_GAIN, '1);
      write_reg(CSR_NOTE_TYPE, '1);
      write_reg(CSR_SPARE_LO, $urandom);
      write_reg(CSR_SPARE_HI, $urandom);
      queue_audio(PEAK_POS);
      queue_audio(PEAK_POS);
      queue_audio(PEAK_NEG);
      queue_audio(PEAK_NEG);
      queue_audio(1);
      drain_echoes();

      // Largest base delay with quarter notes sits right at the upper clamp.
      write_reg(CSR_INITIAL_DELAY, '1);
      write_reg(CSR_NOTE_TYPE, {CSR_DATA_W{1'b0}} | NOTE_QUARTER);
      write_reg(CSR_OUTPUT_GAIN, '0);
      queue_audio(PEAK_POS);
      queue_audio(PEAK_NEG);
      drain_echoes();

      // No tap yet: the register base delay governs.
      repeat (PRE_TAP_PHASES) begin
         setup_phase();
         random_phase(1'b0);
      end

      // Tap history walk-through at nominal gains.
      write_reg(CSR_DECAY_GAIN, DECAY_GAIN_RST);
      write_reg(CSR_MIX_LEVEL, MIX_LEVEL_RST);
      write_reg(CSR_OUTPUT_GAIN, OUTPUT_GAIN_RST);
      write_reg(CSR_NOTE_TYPE, {CSR_DATA_W{1'b0}} | NOTE_QUARTER);
      queue_tap(500);                  // first tap, gap from time zero
      queue_tap(500 + 1999);           // just inside the limit
      queue_tap(500 + 1999 + 2000);    // at the limit, clears history
      queue_tap(32'hFFFF_FF00);
      queue_tap(32'h0000_0010);        // gap across the time wrap
      queue_tap(32'h0000_0010);
      queue_tap(32'h0000_0010 + 3000);
      queue_tap(32'h0000_0010 + 3000); // lone zero gap: base delay zero
      queue_audio(PEAK_POS);
      queue_audio(PEAK_NEG);
      for (int g = 1; g <= TAP_HISTORY + 1; g++)
         queue_tap(stim_last_tap + g); // fill and wrap the history
      drain_echoes();

      repeat (TAP_PHASES) begin
         setup_phase();
         random_phase(1'b1);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && owed_echoes.size() == 0)
         $display("tap_tempo_feedback_echo_tb: clean");
      else
         $display("tap_tempo_feedback_echo_tb: errors");
      $finish;
   end

endmodule
